>>> rtl/core/art_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range tracker package
// Field widths, status and kind codes, channel payload types.
// ----------------------------------------------------------------------------
package art_pkg;

   localparam int NUM_BLOCKS_DEF   = 1024;
   localparam int MAX_OPS_DEF      = 16;
   localparam int ADDRESS_BITS_DEF = 64;

   localparam int BLOCK_W  = 10;
   localparam int OP_W     = 4;
   localparam int ADDR_W   = 64;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] ST_UPDATED      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SKIPPED      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OUT_OF_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DESCRIPTOR   = 2'd3;

   localparam logic KIND_ACCESS     = 1'b0;
   localparam logic KIND_DESCRIPTOR = 1'b1;

   typedef struct packed {
      logic                kind;
      logic [BLOCK_W-1:0]  block;
      logic [OP_W-1:0]     operation;
      logic [ADDR_W-1:0]   address;
      logic                tracked;
      logic [COUNT_W-1:0]  op_count;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   low_address;
      logic [ADDR_W-1:0]   high_address;
   } rsp_payload_type;

endpackage

>>> rtl/core/art_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range tracker channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface art_req_if import art_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface art_rsp_if import art_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/address_range_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address range tracker
// Per-block, per-operation minimum and maximum of traced access addresses.
// ----------------------------------------------------------------------------
// Each request first reads the block table and the range memory through
// their registered read ports, then compares, writes back and loads the
// response register; a new request is taken once the previous one has left
// the write-back step, and a full response register that is not taken holds
// it there. After reset the block table is swept clear, one entry a cycle,
// over all NUM_BLOCKS entries, and meanwhile no request is taken. A descriptor
// resets all slots of its block at once through a per-block mask of written
// slots, so the range memory itself is never swept. Responses carry status
// updated, skipped, out of range or descriptor stored, and the slot bounds
// only on an update.
module address_range_tracker_top import art_pkg::*; #(
   parameter int NUM_BLOCKS     = NUM_BLOCKS_DEF,
   parameter int MAX_OPERATIONS = MAX_OPS_DEF,
   parameter int ADDRESS_BITS   = ADDRESS_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   art_req_if.sink   req_bus,
   art_rsp_if.source rsp_bus
);

   localparam int BLK_AW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int NUM_SLOTS = NUM_BLOCKS * MAX_OPERATIONS;
   localparam int SLOT_AW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int OP_IW     = (MAX_OPERATIONS > 1) ? $clog2(MAX_OPERATIONS) : 1;
   localparam int ENTRY_W   = MAX_OPERATIONS + 1 + COUNT_W;
   localparam int RANGE_W   = 2 * ADDRESS_BITS;

   // control
   logic                    clearing_ff, clearing_in;
   logic [BLK_AW-1:0]       clr_cnt_ff, clr_cnt_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // stage payload
   logic                    s1_kind_ff, s1_in_range_ff, s1_tracked_ff;
   logic [OP_W-1:0]         s1_op_ff;
   logic [ADDRESS_BITS-1:0] s1_addr_ff;
   logic [COUNT_W-1:0]      s1_count_ff;
   logic [BLK_AW-1:0]       s1_blk_ff;
   logic [SLOT_AW-1:0]      s1_slot_ff;
   rsp_payload_type         rsp_data_ff, rsp_data_in;

   logic                    req_accept, do_complete;
   logic [BLK_AW-1:0]       req_blk;
   logic [SLOT_AW-1:0]      req_slot;
   logic [COUNT_W-1:0]      req_count;
   logic                    req_in_range;

   logic                    blk_wr_en, blk_upd;
   logic [BLK_AW-1:0]       blk_wr_addr;
   logic [ENTRY_W-1:0]      blk_wr_data, blk_upd_data, blk_rd_data;
   logic                    rng_wr_en, rng_upd;
   logic [RANGE_W-1:0]      rng_wr_data, rng_rd_data;

   logic [MAX_OPERATIONS-1:0] ent_mask;
   logic                      ent_tracked, slot_written;
   logic [COUNT_W-1:0]        ent_count;
   logic [ADDRESS_BITS-1:0]   cur_low, cur_high, new_low, new_high;

   // request side
   assign req_bus.ready = !clearing_ff && !s1_valid_ff;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign req_blk       = BLK_AW'(req_bus.payload.block);
   assign req_in_range  = int'(req_bus.payload.block) < NUM_BLOCKS;
   assign req_slot      = SLOT_AW'(req_blk * MAX_OPERATIONS)
                          + SLOT_AW'(OP_IW'(req_bus.payload.operation));
   assign req_count     = (int'(req_bus.payload.op_count) > MAX_OPERATIONS)
                          ? COUNT_W'(MAX_OPERATIONS) : req_bus.payload.op_count;

   assign do_complete = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);

   // read-modify-write
   assign ent_mask     = blk_rd_data[ENTRY_W-1 -: MAX_OPERATIONS];
   assign ent_tracked  = blk_rd_data[COUNT_W];
   assign ent_count    = blk_rd_data[COUNT_W-1:0];
   assign slot_written = ent_mask[OP_IW'(s1_op_ff)];
   assign cur_low      = slot_written ? rng_rd_data[ADDRESS_BITS-1:0] : '1;
   assign cur_high     = slot_written ? rng_rd_data[RANGE_W-1:ADDRESS_BITS] : '0;
   assign new_low      = (s1_addr_ff < cur_low) ? s1_addr_ff : cur_low;
   assign new_high     = (s1_addr_ff > cur_high) ? s1_addr_ff : cur_high;
   assign rng_wr_data  = {new_high, new_low};

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.status = ST_SKIPPED;
      blk_upd            = 1'b0;
      blk_upd_data       = blk_rd_data;
      rng_upd            = 1'b0;
      if (!s1_in_range_ff) begin
         rsp_data_in.status = ST_SKIPPED;
      end else if (s1_kind_ff == KIND_DESCRIPTOR) begin
         rsp_data_in.status = ST_DESCRIPTOR;
         blk_upd            = 1'b1;
         blk_upd_data       = {{MAX_OPERATIONS{1'b0}}, s1_tracked_ff, s1_count_ff};
      end else if (!ent_tracked) begin
         rsp_data_in.status = ST_SKIPPED;
      end else if (COUNT_W'(s1_op_ff) >= ent_count) begin
         rsp_data_in.status = ST_OUT_OF_RANGE;
      end else begin
         rsp_data_in.status       = ST_UPDATED;
         rsp_data_in.low_address  = ADDR_W'(new_low);
         rsp_data_in.high_address = ADDR_W'(new_high);
         blk_upd                  = 1'b1;
         blk_upd_data[COUNT_W + 1 + OP_IW'(s1_op_ff)] = 1'b1;
         rng_upd                  = 1'b1;
      end
   end

   assign rng_wr_en   = do_complete && rng_upd;
   assign blk_wr_en   = clearing_ff || (do_complete && blk_upd);
   assign blk_wr_addr = clearing_ff ? clr_cnt_ff : s1_blk_ff;
   assign blk_wr_data = clearing_ff ? '0 : blk_upd_data;

   // next state
   always_comb begin
      clearing_in  = clearing_ff && (clr_cnt_ff != BLK_AW'(NUM_BLOCKS - 1));
      clr_cnt_in   = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      s1_valid_in  = req_accept || (s1_valid_ff && !do_complete);
      rsp_valid_in = do_complete || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold request fields for the write-back cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff     <= req_bus.payload.kind;
         s1_in_range_ff <= req_in_range;
         s1_tracked_ff  <= req_bus.payload.tracked;
         s1_op_ff       <= req_bus.payload.operation;
         s1_addr_ff     <= req_bus.payload.address[ADDRESS_BITS-1:0];
         s1_count_ff    <= req_count;
         s1_blk_ff      <= req_blk;
         s1_slot_ff     <= req_slot;
      end
      if (do_complete) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   art_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_blk_ram (
      .clock   (clock),
      .wr_en   (blk_wr_en),
      .wr_addr (blk_wr_addr),
      .wr_data (blk_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_blk),
      .rd_data (blk_rd_data)
   );

   art_ram #(
      .WIDTH (RANGE_W),
      .DEPTH (NUM_SLOTS)
   ) u_rng_ram (
      .clock   (clock),
      .wr_en   (rng_wr_en),
      .wr_addr (s1_slot_ff),
      .wr_data (rng_wr_data),
      .rd_en   (req_accept),
      .rd_addr (req_slot),
      .rd_data (rng_rd_data)
   );

   // checks
   a_accept_enters_stage: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not enter the write-back stage");

   a_free_output_completes: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !rsp_valid_ff |=> rsp_valid_ff && !s1_valid_ff)
      else $error("request stalled with a free response register");

   a_range_write_reports_update: assert property (@(posedge clock) disable iff (reset)
      rng_wr_en |=> rsp_valid_ff && rsp_data_ff.status == ST_UPDATED)
      else $error("range write without an updated response");

   a_clear_pass_idle: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !rsp_valid_ff)
      else $error("request in flight during the clearing pass");

endmodule

>>> rtl/core/art_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module art_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
